FILE: rtl/mfbr_pkg.sv
// Package for the MSB-first bit reader: sizes, function and status codes,
// and the command record passed from the front end to the execution unit.
// No dependencies.
package mfbr_pkg;

    // Byte queue depth and the widths that follow from it.
    localparam int QUEUE_BYTES = 16;
    localparam int IDX_W       = $clog2(QUEUE_BYTES);
    localparam int CNT_W       = $clog2(QUEUE_BYTES + 1);
    localparam int HELD_W      = $clog2(QUEUE_BYTES * 8 + 1);
    localparam int CMP_W       = (HELD_W > 7) ? HELD_W : 7;

    // Largest read in bits.
    localparam int MAX_READ    = 64;

    // Function codes on the input selector.
    localparam logic [1:0] FN_PUSH  = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_ALIGN = 2'd2;
    localparam logic [1:0] FN_FLUSH = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_READ  = 2'd1,
        OP_ALIGN = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    // Decoded command held in the queue between front end and back end.
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
        logic       too_long;   // read longer than MAX_READ
        logic       zero_len;   // read of zero bits
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_TAKE  = 2'd2,
        S_DONE  = 2'd3
    } t_state;

endpackage

FILE: rtl/mfbr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mfbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mfbr_front.sv
// Front end of the bit reader: accepts input transactions, decodes the
// function and read length, and holds decoded commands in a two-entry queue.
// Depends on mfbr_pkg.
module mfbr_front
    import mfbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    t_cmd       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;

    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Decode the incoming transaction.
    always_comb begin
        w_cmd.data_byte = i_s_tdata[7:0];
        w_cmd.bit_count = i_s_tdata[14:8];
        w_cmd.too_long  = (i_s_tdata[14:8] > 7'(MAX_READ));
        w_cmd.zero_len  = (i_s_tdata[14:8] == 7'd0);
        unique case (i_s_tuser)
            FN_PUSH:  w_cmd.op = OP_PUSH;
            FN_READ:  w_cmd.op = OP_READ;
            FN_ALIGN: w_cmd.op = OP_ALIGN;
            default:  w_cmd.op = OP_FLUSH;
        endcase
    end

    assign o_s_tready  = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_entry[r_rd_ptr];
    assign w_push      = i_s_tvalid && o_s_tready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/mfbr_back.sv
// Back end of the bit reader: byte queue bookkeeping, bit extraction one
// byte per step, the consumed-bit counter and the output register.
// Depends on mfbr_pkg and mfbr_ram.
module mfbr_back
    import mfbr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cmd_valid,
    output logic         o_cmd_ready,
    input  t_cmd         i_cmd,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,
    output logic [1:0]   o_m_tuser
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0]       r_offset, n_offset;
    logic [31:0]      r_consumed, n_consumed;
    logic [63:0]      r_acc, n_acc;
    logic [6:0]       r_remain, n_remain;
    logic [1:0]       r_status, n_status;

    logic             r_out_valid;
    logic [63:0]      r_out_value;
    logic [1:0]       r_out_status;
    logic [7:0]       r_out_held;
    logic [31:0]      r_out_cons;

    logic             w_ram_we;
    logic             w_ram_re;
    logic [IDX_W-1:0] w_tail;
    logic [7:0]       w_rdata;
    logic [HELD_W-1:0] w_held;
    logic [CNT_W:0]   w_tail_sum;
    logic [IDX_W-1:0] w_head_inc;
    logic             w_full;
    logic             w_out_free;

    // Extraction step signals.
    logic [3:0]       w_avail;
    logic [3:0]       w_take;
    logic [7:0]       w_shifted;
    logic [7:0]       w_bits;
    logic [3:0]       w_new_off;

    mfbr_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_tail),
        .i_wdata (i_cmd.data_byte),
        .i_re    (w_ram_re),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // The head offset is nonzero only while a byte is held, so the held
    // bit count is simply count * 8 - offset.
    assign w_held     = (HELD_W'(r_count) << 3) - HELD_W'(r_offset);
    assign w_tail_sum = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);
    assign w_tail     = (w_tail_sum >= (CNT_W + 1)'(QUEUE_BYTES))
                        ? IDX_W'(w_tail_sum - (CNT_W + 1)'(QUEUE_BYTES))
                        : IDX_W'(w_tail_sum);
    assign w_head_inc = (r_head == IDX_W'(QUEUE_BYTES - 1)) ? '0 : r_head + 1'b1;
    assign w_full     = (r_count == CNT_W'(QUEUE_BYTES));
    assign w_out_free = !r_out_valid || i_m_tready;

    assign w_avail   = 4'd8 - {1'b0, r_offset};
    assign w_take    = (r_remain < 7'(w_avail)) ? r_remain[3:0] : w_avail;
    assign w_shifted = w_rdata << r_offset;
    assign w_bits    = w_shifted >> (4'd8 - w_take);
    assign w_new_off = {1'b0, r_offset} + w_take;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_READ && !i_cmd.too_long && !i_cmd.zero_len
                        && (CMP_W'(i_cmd.bit_count) <= CMP_W'(w_held))) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FETCH: n_state = S_TAKE;
            S_TAKE: begin
                if (r_remain == 7'(w_take)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_cmd_ready = (r_state == S_IDLE);
        w_ram_re    = (r_state == S_FETCH);
        w_ram_we    = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.op == OP_PUSH) && !w_full;
    end

    // Datapath next values.
    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_offset   = r_offset;
        n_consumed = r_consumed;
        n_acc      = r_acc;
        n_remain   = r_remain;
        n_status   = r_status;
        unique case (r_state)
            S_IDLE: begin
                n_acc    = '0;
                n_status = ST_OK;
                n_remain = i_cmd.bit_count;
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (i_cmd.too_long
                                || (CMP_W'(i_cmd.bit_count) > CMP_W'(w_held))) begin
                                n_status = ST_UNDER;
                            end
                        end
                        OP_ALIGN: begin
                            if (r_count != '0 && r_offset != 3'd0) begin
                                n_consumed = r_consumed + 32'(w_avail);
                                n_head     = w_head_inc;
                                n_count    = r_count - 1'b1;
                                n_offset   = 3'd0;
                            end
                        end
                        default: begin
                            n_head   = '0;
                            n_count  = '0;
                            n_offset = 3'd0;
                        end
                    endcase
                end
            end
            S_TAKE: begin
                n_acc      = (r_acc << w_take) | 64'(w_bits);
                n_remain   = r_remain - 7'(w_take);
                n_consumed = r_consumed + 32'(w_take);
                if (w_new_off == 4'd8) begin
                    n_head   = w_head_inc;
                    n_count  = r_count - 1'b1;
                    n_offset = 3'd0;
                end else begin
                    n_offset = w_new_off[2:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_count    <= '0;
            r_offset   <= 3'd0;
            r_consumed <= '0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_offset   <= n_offset;
            r_consumed <= n_consumed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_remain <= n_remain;
        r_status <= n_status;
    end

    // Output register: loaded when a result is finished and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_value  <= r_acc;
            r_out_status <= r_status;
            r_out_held   <= 8'(w_held);
            r_out_cons   <= r_consumed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cons, r_out_held, r_out_value};
    assign o_m_tuser  = r_out_status;

endmodule

FILE: rtl/msb_first_bit_reader.sv
// MSB-first bit reader over a byte stream. A transaction passes the front-end
// queue, the idle and done states of the execution state machine and the output
// register; a served read also steps through the fetch and take states once per
// queue byte it touches (up to 9 bytes), using the single RAM read port. The
// execution state machine takes a new item only in its idle state, once the last
// one is done. Reset (i_rst_n low, synchronous) empties the queue,
// clears the bit offset and the consumed-bit counter, and drops pending results.
// Depends on mfbr_pkg, mfbr_front, mfbr_back and mfbr_ram.
module msb_first_bit_reader
    import mfbr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // [7:0] data_byte, [14:8] bit_count, [15] zero
    input  logic [1:0]   i_s_tuser,   // [1:0] func
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,   // [63:0] value, [71:64] bits_held,
                                      // [103:72] bits_consumed
    output logic [1:0]   o_m_tuser    // [1:0] status
);

    // Decoded commands flow from the front end through its small queue into
    // the execution unit, so input acceptance continues while a read is
    // still stepping through bytes or a result is waiting at the output, until that queue is full.
    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_ready;

    mfbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // The execution unit owns the byte queue, the head/count/offset state
    // and the consumed-bit counter. Each transaction yields exactly one result.
    mfbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

FILE: rtl/mfbr_checker.sv
// Port-level checks for the MSB-first bit reader, bound to the top level.
// Depends on mfbr_pkg and msb_first_bit_reader.
module mfbr_checker
    import mfbr_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [15:0]  i_s_tdata,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // Reset drops any pending result.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_UNDER
                        || o_m_tuser == ST_FULL))
        else $error("undefined status code");

    // A refused request returns a zero value.
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != ST_OK) |-> (o_m_tdata[63:0] == 64'd0))
        else $error("nonzero value on refused request");

    // A stalled result holds.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

endmodule

bind msb_first_bit_reader mfbr_checker u_mfbr_checker (.*);

FILE: verif/msb_first_bit_reader_tb.sv
// Self-checking testbench for msb_first_bit_reader: queued push/read/align/flush
// transactions with random gaps on both streams, checked against an in-bench predictor.
// Depends on mfbr_pkg and the msb_first_bit_reader RTL.
module msb_first_bit_reader_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mfbr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 780;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [6:0] bit_count;
    } reader_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [7:0]  bits_held;
        logic [31:0] bits_consumed;
    } reader_result_t;

    typedef struct {
        logic [7:0]  bytes [0:QUEUE_BYTES-1];
        int unsigned head;
        int unsigned count;
        int unsigned offset;
        logic [31:0] consumed;
    } reader_state_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [15:0]  i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [103:0] o_m_tdata;
    logic [1:0]   o_m_tuser;

    reader_item_t   pending_items[$];
    reader_result_t expected_results[$];
    reader_state_t  reader_now;
    reader_state_t  reader_plan;
    reader_item_t   item_on_bus;
    int             errors = 0;
    int             cycles = 0;
    int             send_gap = 0;
    int             send_calm = 0;
    int             recv_stall = 0;
    int             recv_calm = 0;

    msb_first_bit_reader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned held_bits(reader_state_t st);
        return (st.count == 0) ? 0 : st.count * 8 - st.offset;
    endfunction

    function automatic void drop_head_byte(inout reader_state_t st);
        st.head   = (st.head + 1) % QUEUE_BYTES;
        st.count  = st.count - 1;
        st.offset = 0;
    endfunction

    // Applies one transaction to the bit reader state and returns its result.
    function automatic reader_result_t advance_reader(inout reader_state_t st,
                                                      input reader_item_t it);
        reader_result_t r;
        int unsigned    k;
        r = '0;
        r.status = ST_OK;
        case (it.op)
            OP_PUSH: begin
                if (st.count >= QUEUE_BYTES) begin
                    r.status = ST_FULL;
                end else begin
                    st.bytes[(st.head + st.count) % QUEUE_BYTES] = it.data_byte;
                    st.count = st.count + 1;
                end
            end
            OP_READ: begin
                if (it.bit_count > MAX_READ || it.bit_count > held_bits(st)) begin
                    r.status = ST_UNDER;
                end else begin
                    for (k = 0; k < it.bit_count; k++) begin
                        r.value   = {r.value[62:0], st.bytes[st.head][7 - st.offset]};
                        st.offset = st.offset + 1;
                        if (st.offset == 8)
                            drop_head_byte(st);
                    end
                    st.consumed = st.consumed + it.bit_count;
                end
            end
            OP_ALIGN: begin
                if (st.count != 0 && st.offset != 0) begin
                    st.consumed = st.consumed + (8 - st.offset);
                    drop_head_byte(st);
                end
            end
            default: begin
                st.head   = 0;
                st.count  = 0;
                st.offset = 0;
            end
        endcase
        r.bits_held     = 8'(held_bits(st));
        r.bits_consumed = st.consumed;
        return r;
    endfunction

    function automatic void clear_state(inout reader_state_t st);
        st.head     = 0;
        st.count    = 0;
        st.offset   = 0;
        st.consumed = '0;
    endfunction

    // No idling for half of the picks, short gaps for most others, a few long ones,
    // and now and then a calm stretch with no idling at all.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 199);
        if (r == 0) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 100)
            return 0;
        if (r < 170)
            return $urandom_range(1, 3);
        if (r < 195)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Adds an item to the pending list and keeps the planning copy in step.
    function automatic void plan_item(t_op op, logic [7:0] data_byte,
                                      logic [6:0] bit_count);
        reader_item_t   it;
        reader_result_t unused;
        it.op        = op;
        it.data_byte = data_byte;
        it.bit_count = bit_count;
        pending_items.push_back(it);
        unused = advance_reader(reader_plan, it);
    endfunction

    task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            errors++;
        end
    endtask

    // Driver: presents pending items, predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(advance_reader(reader_now, item_on_bus));
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item_on_bus = pending_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {1'b0, item_on_bus.bit_count, item_on_bus.data_byte};
                    i_s_tuser  <= item_on_bus.op;
                    send_gap = pick_gap(send_calm);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        reader_result_t want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("value", want.value, o_m_tdata[63:0]);
                    compare_field("status", 64'(want.status), 64'(o_m_tuser));
                    compare_field("bits_held", 64'(want.bits_held), 64'(o_m_tdata[71:64]));
                    compare_field("bits_consumed", 64'(want.bits_consumed),
                                  64'(o_m_tdata[103:72]));
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                recv_stall = pick_gap(recv_calm);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("msb_first_bit_reader_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int          n;
        int          r;
        int unsigned held;
        int unsigned top;
        clear_state(reader_now);
        clear_state(reader_plan);

        // Directed part: empty-queue cases, filling to the brim and one more,
        // oversized and full-width reads, align off and on a byte boundary,
        // a short-of-data read after flush.
        plan_item(OP_READ, 8'h00, 7'd0);
        plan_item(OP_ALIGN, 8'h00, 7'd0);
        plan_item(OP_FLUSH, 8'h00, 7'd0);
        plan_item(OP_PUSH, 8'hFF, 7'd0);
        plan_item(OP_PUSH, 8'h00, 7'd0);
        plan_item(OP_PUSH, 8'hA5, 7'd0);
        plan_item(OP_PUSH, 8'h5A, 7'd0);
        for (n = 0; n < 12; n++)
            plan_item(OP_PUSH, 8'($urandom_range(0, 255)), 7'd0);
        plan_item(OP_PUSH, 8'h3C, 7'd0);
        plan_item(OP_READ, 8'h00, 7'd127);
        plan_item(OP_READ, 8'h00, 7'd64);
        plan_item(OP_READ, 8'h00, 7'd5);
        plan_item(OP_ALIGN, 8'h00, 7'd0);
        plan_item(OP_ALIGN, 8'h00, 7'd0);
        plan_item(OP_FLUSH, 8'h00, 7'd0);
        plan_item(OP_READ, 8'h00, 7'd1);

        // Random part: mostly pushes and in-range reads so the queue stays busy,
        // with some underflows, overlong reads, aligns, flushes and fill bursts.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            held = held_bits(reader_plan);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                repeat (18)
                    plan_item(OP_PUSH, 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)));
            end else if (r < ((held < 64) ? 55 : 28)) begin
                plan_item(OP_PUSH, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end else if (r < 84) begin
                top = (held > MAX_READ) ? MAX_READ : held;
                plan_item(OP_READ, 8'($urandom_range(0, 255)), 7'($urandom_range(0, top)));
            end else if (r < 90) begin
                if (held < 127)
                    plan_item(OP_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(held + 1, 127)));
                else
                    plan_item(OP_READ, 8'($urandom_range(0, 255)),
                              7'($urandom_range(65, 127)));
            end else if (r < 97) begin
                plan_item(OP_ALIGN, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end else begin
                plan_item(OP_FLUSH, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("msb_first_bit_reader_tb OK");
        else
            $display("msb_first_bit_reader_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mfbr_pkg.sv
rtl/mfbr_ram.sv
rtl/mfbr_front.sv
rtl/mfbr_back.sv
rtl/msb_first_bit_reader.sv
rtl/mfbr_checker.sv
verif/msb_first_bit_reader_tb.sv
